// ===== rtl/svf_pkg.sv =====
// shared types and constants for the state-variable filter with air smoother
`default_nettype none

package svf_pkg;

   localparam int NUM_CHANNELS = 8;
   // channel count is a power of two, so the channel wraps by its low bits
   localparam int CHAN_W       = $clog2(NUM_CHANNELS);
   localparam int IN_CHAN_W    = 3;
   localparam int SAMPLE_W     = 24;
   localparam int STATE_W      = 32;
   localparam int COEF_W       = 24;
   localparam int AIR_W        = 23;
   localparam int MODE_W       = 2;
   localparam int OPND_W       = 48;
   localparam int CHUNK_W      = 24;
   localparam int PROD_W       = 2 * (COEF_W + 1);
   localparam int ACC_W        = 64;
   localparam int FRAC_W       = 22;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = 3;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 <<< (FRAC_W - 1));

   localparam logic signed [OPND_W-1:0] SAT_MAX =
      OPND_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
   localparam logic signed [OPND_W-1:0] SAT_MIN =
      OPND_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

   // response selection, the unused code falls back to lowpass
   localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HP = 2'd2;

   // register indexes, byte address is four times the index
   localparam logic [CSR_IDX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_A2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AIR     = 3'd6;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
      logic [COEF_W-1:0] a3;
      logic [COEF_W-1:0] damping;
      logic [COEF_W-1:0] gain;
      logic [AIR_W-1:0]  air;
   } cfg_type;

   typedef struct packed {
      logic signed [STATE_W-1:0] s1;
      logic signed [STATE_W-1:0] s2;
      logic signed [STATE_W-1:0] sm;
   } chan_state_type;

   typedef struct packed {
      logic issue;
      logic first;
      logic hi;
   } mac_ctl_type;

   // true when a value does not fit the 32-bit state range
   function automatic logic outside_state(input logic signed [OPND_W-1:0] v);
      logic [OPND_W-STATE_W:0] top;
      top = v[OPND_W-1:STATE_W-1];
      return !((&top) || !(|top));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/svf_csr.sv =====
// register file for mode and coefficients behind the configuration port
`default_nettype none

module svf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [svf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [svf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [svf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output svf_pkg::cfg_type                     cfg
);

   svf_pkg::cfg_type               cfg_ff;
   svf_pkg::cfg_type               cfg_in;
   logic [svf_pkg::CSR_IDX_W-1:0]  idx;
   logic                           wr_en;

   assign idx        = csr_paddr[svf_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            svf_pkg::REG_MODE:    cfg_in.mode    = csr_pwdata[svf_pkg::MODE_W-1:0];
            svf_pkg::REG_A1:      cfg_in.a1      = csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_A2:      cfg_in.a2      = csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_A3:      cfg_in.a3      = csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_DAMPING: cfg_in.damping = csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_GAIN:    cfg_in.gain    = csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_AIR:     cfg_in.air     = csr_pwdata[svf_pkg::AIR_W-1:0];
            default:              cfg_in         = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         svf_pkg::REG_MODE:    csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.mode);
         svf_pkg::REG_A1:      csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.a1);
         svf_pkg::REG_A2:      csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.a2);
         svf_pkg::REG_A3:      csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.a3);
         svf_pkg::REG_DAMPING: csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.damping);
         svf_pkg::REG_GAIN:    csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.gain);
         svf_pkg::REG_AIR:     csr_prdata = svf_pkg::CSR_DATA_W'(cfg_ff.air);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= svf_pkg::MODE_LP;
         cfg_ff.a1      <= svf_pkg::COEF_W'(1868210);
         cfg_ff.a2      <= svf_pkg::COEF_W'(1868210);
         cfg_ff.a3      <= svf_pkg::COEF_W'(1868210);
         cfg_ff.damping <= svf_pkg::COEF_W'(1028016);
         cfg_ff.gain    <= svf_pkg::COEF_W'(1745980);
         cfg_ff.air     <= svf_pkg::AIR_W'(4001222);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/svf_mac.sv =====
// shared coefficient multiply-accumulate unit with round-to-nearest scaling
`default_nettype none

module svf_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire svf_pkg::mac_ctl_type                 ctl,
   input  wire logic        [svf_pkg::COEF_W-1:0]    coef,
   input  wire logic signed [svf_pkg::OPND_W-1:0]    operand,
   output logic signed      [svf_pkg::OPND_W-1:0]    result
);

   localparam int HALF_W = svf_pkg::COEF_W + 1;

   logic signed [HALF_W-1:0]          coef_s;
   logic signed [HALF_W-1:0]          chunk;
   logic signed [svf_pkg::PROD_W-1:0] prod_in;
   logic signed [svf_pkg::PROD_W-1:0] prod_ff;
   logic                              vld_ff;
   logic                              first_ff;
   logic                              hi_ff;
   logic signed [svf_pkg::ACC_W-1:0]  prod_ext;
   logic signed [svf_pkg::ACC_W-1:0]  addend;
   logic signed [svf_pkg::ACC_W-1:0]  acc_ff;
   logic signed [svf_pkg::ACC_W-1:0]  acc_in;

   // operand goes in as an unsigned low chunk and a signed high chunk
   assign coef_s = {1'b0, coef};
   assign chunk  = ctl.hi ?
      {operand[svf_pkg::OPND_W-1], operand[svf_pkg::OPND_W-1:svf_pkg::CHUNK_W]} :
      {1'b0, operand[svf_pkg::CHUNK_W-1:0]};
   assign prod_in = coef_s * chunk;

   assign prod_ext = svf_pkg::ACC_W'(prod_ff);
   assign addend   = hi_ff ?
      {prod_ext[svf_pkg::ACC_W-1-svf_pkg::CHUNK_W:0], {svf_pkg::CHUNK_W{1'b0}}} : prod_ext;

   // the rounding bias seeds the accumulator so the shift rounds to nearest
   always_comb begin
      acc_in = acc_ff;
      if (vld_ff) begin
         acc_in = (first_ff ? svf_pkg::ROUND_BIAS : acc_ff) + addend;
      end
   end

   assign result = svf_pkg::OPND_W'($signed(acc_ff[svf_pkg::ACC_W-1:svf_pkg::FRAC_W]));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl.issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      first_ff <= ctl.first;
      hi_ff    <= ctl.hi;
      acc_ff   <= acc_in;
   end

endmodule

`default_nettype wire

// ===== rtl/svf_state.sv =====
// per-channel integrator and smoother state
`default_nettype none

module svf_state (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [svf_pkg::CHAN_W-1:0]     rd_chan,
   output svf_pkg::chan_state_type             rd_data,
   input  wire logic                           wr_en,
   input  wire logic [svf_pkg::CHAN_W-1:0]     wr_chan,
   input  wire svf_pkg::chan_state_type        wr_data
);

   svf_pkg::chan_state_type st_ff [svf_pkg::NUM_CHANNELS];

   assign rd_data = st_ff[rd_chan];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < svf_pkg::NUM_CHANNELS; i++) begin
            st_ff[i] <= '0;
         end
      end else if (wr_en) begin
         st_ff[wr_chan] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/svf_filter_with_air_pole_core.sv =====
// top level: sequencer around the shared multiply-accumulate unit
//
//  port group  direction  handshake              payload
//  req_*       in         tvalid / tready        tdata: sample_in, tuser: chan
//  rsp_*       out        tvalid / tready        tdata: sample_out, tuser: state_cleared
//  csr_*       in         psel / penable, apb    7 registers at byte address 4*index
//
//  a new item is accepted only once the last is through; highpass mode adds a step
//  to lowpass and bandpass. each coefficient product is two passes through the one
//  25x25 multiplier, and each step waits for its product register and accumulator
//  to drain. reset is synchronous, clears all channel state and sets the registers
//  to defaults. a waiting result holds the sequencer in its final step until rsp_tready;
//  the output register lets the next item be accepted as soon as the result is loaded.
`default_nettype none

module svf_filter_with_air_pole_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [svf_pkg::SAMPLE_W-1:0]        req_tdata,   // [23:0] sample_in
   input  wire logic [svf_pkg::IN_CHAN_W-1:0]       req_tuser,   // [2:0] chan
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [svf_pkg::SAMPLE_W-1:0]        rsp_tdata,   // [23:0] sample_out
   output logic                                     rsp_tuser,   // [0] state_cleared
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [svf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [svf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [svf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   localparam int OW = svf_pkg::OPND_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_V1   = 7'b0000010,
      S_V2   = 7'b0000100,
      S_HP   = 7'b0001000,
      S_Y    = 7'b0010000,
      S_SM   = 7'b0100000,
      S_DONE = 7'b1000000
   } seq_state_type;

   // two products per step issue at counts 0..3, one product at 0..1
   localparam logic [2:0] PAIR_ISSUE  = 3'd4;
   localparam logic [2:0] PAIR_LAST   = 3'd5;
   localparam logic [2:0] SINGLE_ISSUE = 3'd2;
   localparam logic [2:0] SINGLE_LAST  = 3'd3;

   svf_pkg::cfg_type         cfg;
   svf_pkg::chan_state_type  rd_st;
   svf_pkg::chan_state_type  wr_st;
   svf_pkg::mac_ctl_type     mac_ctl;
   logic [svf_pkg::COEF_W-1:0] mac_coef;
   logic signed [OW-1:0]     mac_opnd;
   logic signed [OW-1:0]     mac_res;

   seq_state_type            state_ff, state_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [svf_pkg::CHAN_W-1:0] ch_ff, ch_in;
   logic signed [OW-1:0]     x_ff, x_in;
   logic signed [OW-1:0]     s1_ff, s1_in;
   logic signed [OW-1:0]     s2_ff, s2_in;
   logic signed [OW-1:0]     sm_ff, sm_in;
   logic signed [OW-1:0]     v3_ff, v3_in;
   logic signed [OW-1:0]     v1_ff, v1_in;
   logic signed [OW-1:0]     v2_ff, v2_in;
   logic signed [OW-1:0]     hp_ff, hp_in;
   logic signed [OW-1:0]     diff_ff, diff_in;
   logic signed [OW-1:0]     nsm_ff, nsm_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [svf_pkg::SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_clr_ff, rsp_clr_in;

   logic signed [OW-1:0]     n1, n2;
   logic                     ovf;
   logic signed [OW-1:0]     sat;
   logic                     out_free;
   logic                     st_wr;
   logic                     accept;

   svf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   svf_state u_state (
      .clock   (clock),
      .reset   (reset),
      .rd_chan (req_tuser[svf_pkg::CHAN_W-1:0]),
      .rd_data (rd_st),
      .wr_en   (st_wr),
      .wr_chan (ch_ff),
      .wr_data (wr_st)
   );

   svf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .coef    (mac_coef),
      .operand (mac_opnd),
      .result  (mac_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next integrator states and the overflow check
   assign n1  = (v1_ff <<< 1) - s1_ff;
   assign n2  = (v2_ff <<< 1) - s2_ff;
   assign ovf = svf_pkg::outside_state(n1) || svf_pkg::outside_state(n2) ||
                svf_pkg::outside_state(nsm_ff);

   always_comb begin
      priority if (nsm_ff > svf_pkg::SAT_MAX) begin
         sat = svf_pkg::SAT_MAX;
      end else if (nsm_ff < svf_pkg::SAT_MIN) begin
         sat = svf_pkg::SAT_MIN;
      end else begin
         sat = nsm_ff;
      end
   end

   always_comb begin
      wr_st = '0;
      if (!ovf) begin
         wr_st.s1 = n1[svf_pkg::STATE_W-1:0];
         wr_st.s2 = n2[svf_pkg::STATE_W-1:0];
         wr_st.sm = nsm_ff[svf_pkg::STATE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + 3'd1;
      ch_in        = ch_ff;
      x_in         = x_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      sm_in        = sm_ff;
      v3_in        = v3_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      hp_in        = hp_ff;
      diff_in      = diff_ff;
      nsm_in       = nsm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_clr_in   = rsp_clr_ff;
      st_wr        = 1'b0;
      mac_ctl.issue = 1'b0;
      mac_ctl.first = (cnt_ff == 3'd0);
      mac_ctl.hi    = cnt_ff[0];
      mac_coef     = cfg.a1;
      mac_opnd     = s1_ff;

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = 3'd0;
            if (accept) begin
               ch_in    = req_tuser[svf_pkg::CHAN_W-1:0];
               x_in     = OW'($signed(req_tdata));
               s1_in    = OW'(rd_st.s1);
               s2_in    = OW'(rd_st.s2);
               sm_in    = OW'(rd_st.sm);
               v3_in    = OW'($signed(req_tdata)) - OW'(rd_st.s2);
               state_in = S_V1;
            end
         end
         S_V1: begin
            mac_ctl.issue = (cnt_ff < PAIR_ISSUE);
            mac_coef      = cnt_ff[1] ? cfg.a2 : cfg.a1;
            mac_opnd      = cnt_ff[1] ? v3_ff : s1_ff;
            if (cnt_ff == PAIR_LAST) begin
               v1_in    = mac_res;
               cnt_in   = 3'd0;
               state_in = S_V2;
            end
         end
         S_V2: begin
            mac_ctl.issue = (cnt_ff < PAIR_ISSUE);
            mac_coef      = cnt_ff[1] ? cfg.a3 : cfg.a2;
            mac_opnd      = cnt_ff[1] ? v3_ff : s1_ff;
            if (cnt_ff == PAIR_LAST) begin
               v2_in    = s2_ff + mac_res;
               cnt_in   = 3'd0;
               state_in = (cfg.mode == svf_pkg::MODE_HP) ? S_HP : S_Y;
            end
         end
         S_HP: begin
            mac_ctl.issue = (cnt_ff < SINGLE_ISSUE);
            mac_coef      = cfg.damping;
            mac_opnd      = v1_ff;
            if (cnt_ff == SINGLE_LAST) begin
               hp_in    = x_ff - mac_res - v2_ff;
               cnt_in   = 3'd0;
               state_in = S_Y;
            end
         end
         S_Y: begin
            mac_ctl.issue = (cnt_ff < SINGLE_ISSUE);
            mac_coef      = cfg.gain;
            priority case (cfg.mode)
               svf_pkg::MODE_BP: mac_opnd = v1_ff;
               svf_pkg::MODE_HP: mac_opnd = hp_ff;
               default:          mac_opnd = v2_ff;
            endcase
            if (cnt_ff == SINGLE_LAST) begin
               diff_in  = mac_res - sm_ff;
               cnt_in   = 3'd0;
               state_in = S_SM;
            end
         end
         S_SM: begin
            mac_ctl.issue = (cnt_ff < SINGLE_ISSUE);
            mac_coef      = svf_pkg::COEF_W'(cfg.air);
            mac_opnd      = diff_ff;
            if (cnt_ff == SINGLE_LAST) begin
               nsm_in   = sm_ff + mac_res;
               cnt_in   = 3'd0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cnt_in = 3'd0;
            if (out_free) begin
               st_wr        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_clr_in   = ovf;
               rsp_data_in  = ovf ? '0 : sat[svf_pkg::SAMPLE_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      x_ff        <= x_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      sm_ff       <= sm_in;
      v3_ff       <= v3_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      hp_ff       <= hp_in;
      diff_ff     <= diff_in;
      nsm_ff      <= nsm_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clr_ff  <= rsp_clr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clr_ff;

endmodule

`default_nettype wire

// ===== tb/sv/svf_filter_with_air_pole_core_tb.sv =====
// self-checking testbench for the multichannel state-variable filter with air smoother
`timescale 1ns / 1ps

module svf_filter_with_air_pole_core_tb;
   import svf_pkg::*;

   localparam logic [CSR_IDX_W-1:0]      REG_NONE    = 3'd7;   // no register behind it
   localparam logic [MODE_W-1:0]         MODE_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
   localparam logic [COEF_W-1:0]         COEF_RST    = 24'd1868210;
   localparam logic [COEF_W-1:0]         DAMPING_RST = 24'd1028016;
   localparam logic [COEF_W-1:0]         GAIN_RST    = 24'd1745980;
   localparam logic [AIR_W-1:0]          AIR_RST     = 23'd4001222;
   localparam logic [AIR_W-1:0]          AIR_UNITY   = 23'd4194304;
   localparam logic [COEF_W-1:0]         COEF_UNITY  = 24'd4194304;

   typedef struct {
      logic [SAMPLE_W-1:0] sample_out;
      logic                state_cleared;
   } filt_out_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;    // [23:0] sample_in
   logic [IN_CHAN_W-1:0]  req_tuser = '0;    // [2:0] chan
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;         // [23:0] sample_out
   logic                  rsp_tuser;         // [0] state_cleared
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the block's registers and per-channel state
   cfg_type                   filt_cfg;
   logic signed [STATE_W-1:0] integ_bp [NUM_CHANNELS] = '{default: '0};
   logic signed [STATE_W-1:0] integ_lp [NUM_CHANNELS] = '{default: '0};
   logic signed [STATE_W-1:0] air_state [NUM_CHANNELS] = '{default: '0};

   filt_out_t pending_filter_out [$];

   int err_count     = 0;
   int samples_sent  = 0;
   int outputs_seen  = 0;
   int clears_seen   = 0;
   int reg_writes    = 0;
   int req_idle_pct  = 28;
   int rsp_stall_pct = 48;

   svf_filter_with_air_pole_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // divide by 2^22, round to nearest with ties toward plus infinity
   function automatic longint round_q22(input longint p);
      return (p + 64'sd2097152) >>> FRAC_W;
   endfunction

   function automatic bit fits_state(input longint v);
      return v <= 64'sd2147483647 && v >= -64'sd2147483648;
   endfunction

   function automatic filt_out_t svf_predict(input logic [IN_CHAN_W-1:0] chan,
                                              input logic signed [SAMPLE_W-1:0] smp);
      int unsigned ch;
      longint x, s1, s2, sm, v3, v1, v2, n1, n2, y, nsm;
      longint a1, a2, a3, damp, gain, air;
      filt_out_t res;
      ch   = chan % NUM_CHANNELS;
      a1   = filt_cfg.a1;
      a2   = filt_cfg.a2;
      a3   = filt_cfg.a3;
      damp = filt_cfg.damping;
      gain = filt_cfg.gain;
      air  = filt_cfg.air;
      x    = smp;
      s1   = integ_bp[ch];
      s2   = integ_lp[ch];
      sm   = air_state[ch];
      v3   = x - s2;
      v1   = round_q22(a1 * s1 + a2 * v3);
      v2   = s2 + round_q22(a2 * s1 + a3 * v3);
      n1   = 2 * v1 - s1;
      n2   = 2 * v2 - s2;
      case (filt_cfg.mode)
         MODE_BP: y = round_q22(v1 * gain);
         MODE_HP: y = round_q22((x - round_q22(damp * v1) - v2) * gain);
         default: y = round_q22(v2 * gain);
      endcase
      nsm = sm + round_q22(air * (y - sm));
      if (!fits_state(n1) || !fits_state(n2) || !fits_state(nsm)) begin
         integ_bp[ch]      = '0;
         integ_lp[ch]      = '0;
         air_state[ch]     = '0;
         res.sample_out    = '0;
         res.state_cleared = 1'b1;
         clears_seen++;
      end else begin
         integ_bp[ch]  = n1[STATE_W-1:0];
         integ_lp[ch]  = n2[STATE_W-1:0];
         air_state[ch] = nsm[STATE_W-1:0];
         if (nsm > 64'sd8388607) nsm = 64'sd8388607;
         if (nsm < -64'sd8388608) nsm = -64'sd8388608;
         res.sample_out    = nsm[SAMPLE_W-1:0];
         res.state_cleared = 1'b0;
      end
      return res;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(input logic [CSR_IDX_W-1:0] idx);
      case (idx)
         REG_MODE:    return CSR_DATA_W'(filt_cfg.mode);
         REG_A1:      return CSR_DATA_W'(filt_cfg.a1);
         REG_A2:      return CSR_DATA_W'(filt_cfg.a2);
         REG_A3:      return CSR_DATA_W'(filt_cfg.a3);
         REG_DAMPING: return CSR_DATA_W'(filt_cfg.damping);
         REG_GAIN:    return CSR_DATA_W'(filt_cfg.gain);
         REG_AIR:     return CSR_DATA_W'(filt_cfg.air);
         default:     return '0;
      endcase
   endfunction

   // result side: check every transaction, then pick the next ready level
   always @(posedge clock) begin
      filt_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         outputs_seen++;
         if (pending_filter_out.size() == 0) begin
            $error("unexpected result: sample_out %h state_cleared %b", rsp_tdata, rsp_tuser);
            err_count++;
         end else begin
            want = pending_filter_out.pop_front();
            if (rsp_tdata !== want.sample_out) begin
               $error("sample_out mismatch: expected %h, actual %h", want.sample_out, rsp_tdata);
               err_count++;
            end
            if (rsp_tuser !== want.state_cleared) begin
               $error("state_cleared mismatch: expected %b, actual %b",
                      want.state_cleared, rsp_tuser);
               err_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic csr_read(input logic [CSR_IDX_W-1:0] idx, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] got;
      csr_read(idx, got);
      if (got !== reg_value(idx)) begin
         $error("csr_prdata mismatch at index %0d: expected %h, actual %h",
                idx, reg_value(idx), got);
         err_count++;
      end
   endtask

   // only called while nothing is in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      reg_writes++;
      case (idx)
         REG_MODE:    filt_cfg.mode    = value[MODE_W-1:0];
         REG_A1:      filt_cfg.a1      = value[COEF_W-1:0];
         REG_A2:      filt_cfg.a2      = value[COEF_W-1:0];
         REG_A3:      filt_cfg.a3      = value[COEF_W-1:0];
         REG_DAMPING: filt_cfg.damping = value[COEF_W-1:0];
         REG_GAIN:    filt_cfg.gain    = value[COEF_W-1:0];
         REG_AIR:     filt_cfg.air     = value[AIR_W-1:0];
         default:     ;
      endcase
      if (idx != REG_NONE)
         check_reg(idx);
   endtask

   task automatic send_sample(input logic [IN_CHAN_W-1:0] chan,
                              input logic signed [SAMPLE_W-1:0] smp);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 32)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= chan;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      pending_filter_out.push_back(svf_predict(chan, smp));
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic drain_filter();
      req_tvalid <= 1'b0;
      while (pending_filter_out.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return $urandom_range(1) ? '0 : '1;
         3, 4:    return SAMPLE_W'($signed($urandom_range(8192)) - 4096);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return COEF_W'($urandom);
         default: return COEF_W'($urandom_range(COEF_UNITY));
      endcase
   endfunction

   function automatic logic [AIR_W-1:0] pick_air();
      case ($urandom_range(7))
         0:       return '0;
         1:       return AIR_UNITY;
         2:       return AIR_W'($urandom_range(AIR_UNITY, 23'h7FFFFF));   // overshooting smoother
         default: return AIR_W'($urandom_range(AIR_UNITY));
      endcase
   endfunction

   // upper data bits carry noise that the register must drop
   task automatic randomize_filter_setup();
      write_reg(REG_MODE,    {30'($urandom), 2'($urandom_range(3))});
      write_reg(REG_A1,      {8'($urandom), pick_coef()});
      write_reg(REG_A2,      {8'($urandom), pick_coef()});
      write_reg(REG_A3,      {8'($urandom), pick_coef()});
      write_reg(REG_DAMPING, {8'($urandom), pick_coef()});
      write_reg(REG_GAIN,    {8'($urandom), pick_coef()});
      write_reg(REG_AIR,     {9'($urandom), pick_air()});
   endtask

   task automatic restore_default_setup();
      write_reg(REG_MODE,    CSR_DATA_W'(MODE_LP));
      write_reg(REG_A1,      CSR_DATA_W'(COEF_RST));
      write_reg(REG_A2,      CSR_DATA_W'(COEF_RST));
      write_reg(REG_A3,      CSR_DATA_W'(COEF_RST));
      write_reg(REG_DAMPING, CSR_DATA_W'(DAMPING_RST));
      write_reg(REG_GAIN,    CSR_DATA_W'(GAIN_RST));
      write_reg(REG_AIR,     CSR_DATA_W'(AIR_RST));
   endtask

   task automatic test_register_access();
      for (int i = REG_MODE; i <= REG_AIR; i++) check_reg(CSR_IDX_W'(i));
      for (int i = REG_MODE; i <= REG_AIR; i++) begin
         write_reg(CSR_IDX_W'(i), '1);
         write_reg(CSR_IDX_W'(i), '0);
      end
      // a write past the last register must leave every register alone
      write_reg(REG_NONE, $urandom);
      for (int i = REG_MODE; i <= REG_AIR; i++) check_reg(CSR_IDX_W'(i));
      restore_default_setup();
   endtask

   task automatic test_sample_extremes();
      send_sample(3'd0, SAMPLE_MAX);
      send_sample(3'd7, SAMPLE_MIN);
      send_sample(3'd3, '0);
      send_sample(3'd5, '1);
      send_sample(3'd1, 24'sd1);
      send_sample(3'd0, SAMPLE_MAX);
   endtask

   task automatic test_each_mode();
      logic [MODE_W-1:0] modes [4];
      modes = '{MODE_LP, MODE_BP, MODE_HP, MODE_UNUSED};
      foreach (modes[m]) begin
         drain_filter();
         write_reg(REG_MODE, CSR_DATA_W'(modes[m]));
         send_sample(3'd4, SAMPLE_MAX);
         send_sample(3'd4, SAMPLE_MIN);
         send_sample(3'($urandom), pick_sample());
      end
   endtask

   // maximal coefficients blow up the integrators within a few samples
   task automatic test_overflow_clear();
      drain_filter();
      write_reg(REG_MODE, CSR_DATA_W'(MODE_HP));
      write_reg(REG_A1,   '1);
      write_reg(REG_A2,   '1);
      write_reg(REG_A3,   '1);
      write_reg(REG_GAIN, '1);
      write_reg(REG_AIR,  CSR_DATA_W'(23'h7FFFFF));
      repeat (7) send_sample(3'd2, SAMPLE_MAX);
   endtask

   task automatic test_random_traffic();
      int idle_plan [3][2];
      idle_plan = '{'{28, 48}, '{48, 28}, '{0, 0}};
      for (int ph = 0; ph < 3; ph++) begin
         for (int seg = 0; seg < 4; seg++) begin
            drain_filter();
            req_idle_pct  = idle_plan[ph][0];
            rsp_stall_pct = idle_plan[ph][1];
            if (ph == 0 && seg == 0)
               restore_default_setup();
            else
               randomize_filter_setup();
            repeat (167) send_sample(3'($urandom), pick_sample());
         end
      end
   endtask

   initial begin
      filt_cfg = '{mode: MODE_LP, a1: COEF_RST, a2: COEF_RST, a3: COEF_RST,
                   damping: DAMPING_RST, gain: GAIN_RST, air: AIR_RST};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_sample_extremes();
      test_each_mode();
      test_overflow_clear();
      test_random_traffic();

      drain_filter();
      repeat (64) @(posedge clock);
      if (pending_filter_out.size() != 0) begin
         $error("%0d results never arrived", pending_filter_out.size());
         err_count++;
      end

      $display("covered %0d samples over 8 channels and all response modes, %0d results checked",
               samples_sent, outputs_seen);
      $display("%0d register writes, %0d overflow clears predicted, %0d mismatches",
               reg_writes, clears_seen, err_count);
      if (err_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/svf_pkg.sv
rtl/svf_csr.sv
rtl/svf_mac.sv
rtl/svf_state.sv
rtl/svf_filter_with_air_pole_core.sv
tb/sv/svf_filter_with_air_pole_core_tb.sv
